// ----- src/clock_wipe_transition_defines.svh -----
// Assertion macros shared by the clock wipe transition RTL.
`ifndef CLOCK_WIPE_TRANSITION_DEFINES_SVH
`define CLOCK_WIPE_TRANSITION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwt assertion failed");

`endif

// ----- src/cwt_pkg.sv -----
// Package with constants, register indexes and types of the clock wipe transition.
package cwt_pkg;

  localparam int CWT_PIX_W      = 8;
  localparam int CWT_DIM_CFG_W  = 11;
  localparam int CWT_Q15_W      = 16;
  localparam int CWT_Q15_ONE    = 32768;
  localparam int CWT_MAX_DIM    = 1024;
  localparam int CWT_CFG_IDX_W  = 3;
  localparam int CWT_CFG_DATA_W = 16;
  localparam int CWT_DIM_RESET  = 64;

  typedef enum logic [CWT_CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_SWEEP_SINE   = 3'd2,
    CFG_SWEEP_COSINE = 3'd3,
    CFG_SECOND_HALF  = 3'd4,
    CFG_FILL_COLOR   = 3'd5
  } cwt_cfg_idx_t;

  typedef struct packed {
    logic [CWT_Q15_W-1:0] sine;
    logic [CWT_Q15_W-1:0] cosine;
    logic                 second_half;
    logic [CWT_PIX_W-1:0] fill;
  } cwt_sweep_t;

  function automatic logic [CWT_Q15_W-1:0] cwt_clamp_q15(input logic [CWT_Q15_W-1:0] v);
    logic [CWT_Q15_W-1:0] one;
    one = CWT_Q15_W'(CWT_Q15_ONE);
    return (v > one) ? one : v;
  endfunction

endpackage

// ----- src/cwt_if.sv -----
// Valid/ready channel interfaces for the input and result items.
interface cwt_in_if import cwt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CWT_PIX_W-1:0] pixel_prev;
  logic [CWT_PIX_W-1:0] pixel_cur;

  modport source (output valid, output pixel_prev, output pixel_cur, input ready);
  modport sink   (input valid, input pixel_prev, input pixel_cur, output ready);
endinterface

interface cwt_out_if import cwt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CWT_PIX_W-1:0] pixel_out;
  logic                 frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ----- src/cwt_mask.sv -----
// Clock wipe mask decision and pixel selection for one raster position.
module cwt_mask import cwt_pkg::*; #(
  parameter int CNT_W = 10,
  parameter int DIM_W = 11
) (
  input  logic [CNT_W-1:0]     col,
  input  logic [CNT_W-1:0]     row,
  input  logic [DIM_W-1:0]     width,
  input  logic [DIM_W-1:0]     height,
  input  cwt_sweep_t           sweep,
  input  logic [CWT_PIX_W-1:0] pixel_prev,
  input  logic [CWT_PIX_W-1:0] pixel_cur,
  output logic [CWT_PIX_W-1:0] pixel_out
);

  localparam int PROD_W = CWT_Q15_W + CNT_W;

  logic [CNT_W-1:0]     half_w;
  logic [CNT_W-1:0]     half_h;
  logic                 x_neg;
  logic                 y_neg;
  logic [CNT_W-1:0]     abs_x;
  logic [CNT_W-1:0]     abs_y;
  logic [CNT_W-1:0]     mul_s_op;
  logic [CNT_W-1:0]     mul_c_op;
  logic [CWT_Q15_W-1:0] sine_c;
  logic [CWT_Q15_W-1:0] cosine_c;
  logic [PROD_W-1:0]    prod_s;
  logic [PROD_W-1:0]    prod_c;
  logic                 behind;
  logic                 on_axis;

  always_comb begin
    half_w   = CNT_W'(width >> 1);
    half_h   = CNT_W'(height >> 1);
    x_neg    = col < half_w;
    y_neg    = row < half_h;
    abs_x    = x_neg ? (half_w - col) : (col - half_w);
    abs_y    = y_neg ? (half_h - row) : (row - half_h);
    mul_s_op = (x_neg == y_neg) ? abs_x : abs_y;
    mul_c_op = (x_neg == y_neg) ? abs_y : abs_x;
    sine_c   = cwt_clamp_q15(sweep.sine);
    cosine_c = cwt_clamp_q15(sweep.cosine);
    prod_s   = PROD_W'(sine_c) * PROD_W'(mul_s_op);
    prod_c   = PROD_W'(cosine_c) * PROD_W'(mul_c_op);
    behind   = prod_s <= prod_c;
    on_axis  = (col == half_w) || (row == half_h);
    if (on_axis) begin
      pixel_out = sweep.fill;
    end else if (sweep.second_half) begin
      pixel_out = behind ? sweep.fill : pixel_cur;
    end else begin
      pixel_out = behind ? pixel_prev : sweep.fill;
    end
  end

endmodule

// ----- src/clock_wipe_transition.sv -----
// Top level of the clock wipe transition: configuration, raster counters and pipeline.
//
//   channel  direction  handshake            payload
//   in_ch    in         valid/ready          pixel_prev, pixel_cur
//   out_ch   out        valid/ready          pixel_out, frame_end
//   cfg_*    in         write enable only    cfg_index, cfg_data
//
// One item is accepted per cycle unless a stall on out_ch has filled both registers; each item is
// loaded into the input stage register, then its result into the result register, which drives out_ch.
// The one-item-per-cycle rate holds because the two multipliers of the mask fit between
// the input stage register and the result register.
// Synchronous reset clears the counters and the valid flags and sets the configuration registers to their defaults.
// A stall on out_ch holds the result register and then the input stage, so no item is lost.
`include "clock_wipe_transition_defines.svh"

module clock_wipe_transition import cwt_pkg::*; #(
  parameter int MAX_DIM = CWT_MAX_DIM
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CWT_CFG_IDX_W-1:0]  cfg_index,
  input  logic [CWT_CFG_DATA_W-1:0] cfg_data,
  cwt_in_if.sink                    in_ch,
  cwt_out_if.source                 out_ch
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = CNT_W + 1;

  logic [CWT_DIM_CFG_W-1:0] frame_width_r;
  logic [CWT_DIM_CFG_W-1:0] frame_height_r;
  cwt_sweep_t               sweep_r;

  logic [DIM_W-1:0]     width_c;
  logic [DIM_W-1:0]     height_c;
  logic [CNT_W-1:0]     col_r;
  logic [CNT_W-1:0]     row_r;
  logic                 last_col;
  logic                 last_row;
  logic                 accept;

  logic                 s1_valid_r;
  logic [CWT_PIX_W-1:0] s1_prev_r;
  logic [CWT_PIX_W-1:0] s1_cur_r;
  logic [CNT_W-1:0]     s1_col_r;
  logic [CNT_W-1:0]     s1_row_r;
  logic                 s1_end_r;

  logic                 out_valid_r;
  logic [CWT_PIX_W-1:0] out_pixel_r;
  logic                 out_end_r;
  logic [CWT_PIX_W-1:0] pixel_nxt;
  logic                 out_move;
  logic                 s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r       <= CWT_DIM_CFG_W'(CWT_DIM_RESET);
      frame_height_r      <= CWT_DIM_CFG_W'(CWT_DIM_RESET);
      sweep_r.sine        <= '0;
      sweep_r.cosine      <= CWT_Q15_W'(CWT_Q15_ONE);
      sweep_r.second_half <= 1'b0;
      sweep_r.fill        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r       <= cfg_data[CWT_DIM_CFG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r      <= cfg_data[CWT_DIM_CFG_W-1:0];
        CFG_SWEEP_SINE:   sweep_r.sine        <= cfg_data[CWT_Q15_W-1:0];
        CFG_SWEEP_COSINE: sweep_r.cosine      <= cfg_data[CWT_Q15_W-1:0];
        CFG_SECOND_HALF:  sweep_r.second_half <= cfg_data[0];
        CFG_FILL_COLOR:   sweep_r.fill        <= cfg_data[CWT_PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      width_c = DIM_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_DIM)) begin
      width_c = DIM_W'(MAX_DIM);
    end else begin
      width_c = DIM_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      height_c = DIM_W'(1);
    end else if (32'(frame_height_r) > 32'(MAX_DIM)) begin
      height_c = DIM_W'(MAX_DIM);
    end else begin
      height_c = DIM_W'(frame_height_r);
    end
  end

  assign last_col = DIM_W'(col_r) >= (width_c - DIM_W'(1));
  assign last_row = DIM_W'(row_r) >= (height_c - DIM_W'(1));

  assign out_move    = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || out_move;
  assign in_ch.ready = s1_ready;
  assign accept      = in_ch.valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : (row_r + CNT_W'(1));
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (accept) begin
      s1_prev_r <= in_ch.pixel_prev;
      s1_cur_r  <= in_ch.pixel_cur;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_end_r  <= last_col && last_row;
    end
  end

  cwt_mask #(
    .CNT_W(CNT_W),
    .DIM_W(DIM_W)
  ) u_mask (
    .col       (s1_col_r),
    .row       (s1_row_r),
    .width     (width_c),
    .height    (height_c),
    .sweep     (sweep_r),
    .pixel_prev(s1_prev_r),
    .pixel_cur (s1_cur_r),
    .pixel_out (pixel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_move && s1_valid_r) begin
      out_pixel_r <= pixel_nxt;
      out_end_r   <= s1_end_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pixel_r;
  assign out_ch.frame_end = out_end_r;

  `CWT_ASSERT_NEXT(a_wrap_at_frame_end, clk, rst_n, accept && last_col && last_row,
                   (col_r == '0) && (row_r == '0))
  `CWT_ASSERT_NEXT(a_col_advance, clk, rst_n, accept && !last_col,
                   col_r == ($past(col_r) + CNT_W'(1)))
  `CWT_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !in_ch.ready,
                   s1_valid_r && out_valid_r && !out_ch.ready)

endmodule

// ----- bench/tb_clock_wipe_transition.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the clock wipe transition with a mask predictor and scoreboard.
module tb_clock_wipe_transition;
  import cwt_pkg::*;

  localparam int RANDOM_ITEMS     = 1280;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES     = 8;

  localparam logic [CWT_CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CWT_CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [CWT_PIX_W-1:0] pixel_out;
    logic                 frame_end;
  } wipe_result_t;

  // Tracks the raster position and mask settings, and holds the pixels still owed by the block.
  class wipe_frame_tracker;
    int unsigned  width_reg;
    int unsigned  height_reg;
    int unsigned  sine_reg;
    int unsigned  cosine_reg;
    bit           second_half_reg;
    logic [7:0]   fill_reg;
    int unsigned  col_pos;
    int unsigned  row_pos;
    int unsigned  errors;
    wipe_result_t pending_pixels[$];

    function new();
      width_reg       = CWT_DIM_RESET;
      height_reg      = CWT_DIM_RESET;
      sine_reg        = 0;
      cosine_reg      = CWT_Q15_ONE;
      second_half_reg = 1'b0;
      fill_reg        = '0;
      col_pos         = 0;
      row_pos         = 0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CWT_CFG_IDX_W-1:0] idx, logic [CWT_CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = data[CWT_DIM_CFG_W-1:0];
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = data[CWT_DIM_CFG_W-1:0];
        end
        CFG_SWEEP_SINE: begin
          sine_reg = data;
        end
        CFG_SWEEP_COSINE: begin
          cosine_reg = data;
        end
        CFG_SECOND_HALF: begin
          second_half_reg = data[0];
        end
        CFG_FILL_COLOR: begin
          fill_reg = data[CWT_PIX_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) begin
        return 1;
      end
      return (v > CWT_MAX_DIM) ? CWT_MAX_DIM : v;
    endfunction

    function void note_pixel_pair(logic [7:0] prev, logic [7:0] cur);
      int unsigned     w;
      int unsigned     h;
      int unsigned     hw;
      int unsigned     hh;
      longint unsigned s;
      longint unsigned c;
      longint unsigned ax;
      longint unsigned ay;
      bit              last_col;
      bit              last_row;
      bit              xneg;
      bit              yneg;
      bit              behind;
      wipe_result_t    res;
      w        = clamp_dim(width_reg);
      h        = clamp_dim(height_reg);
      s        = (sine_reg > CWT_Q15_ONE) ? CWT_Q15_ONE : sine_reg;
      c        = (cosine_reg > CWT_Q15_ONE) ? CWT_Q15_ONE : cosine_reg;
      hw       = w / 2;
      hh       = h / 2;
      last_col = col_pos >= w - 1;
      last_row = row_pos >= h - 1;
      if (col_pos == hw || row_pos == hh) begin
        res.pixel_out = fill_reg;
      end else begin
        xneg = col_pos < hw;
        yneg = row_pos < hh;
        ax   = xneg ? hw - col_pos : col_pos - hw;
        ay   = yneg ? hh - row_pos : row_pos - hh;
        if (xneg == yneg) begin
          behind = s * ax <= c * ay;
        end else begin
          behind = s * ay <= c * ax;
        end
        if (second_half_reg) begin
          res.pixel_out = behind ? fill_reg : cur;
        end else begin
          res.pixel_out = behind ? prev : fill_reg;
        end
      end
      res.frame_end = last_col && last_row;
      pending_pixels.push_back(res);
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void compare_output(logic [7:0] pix, logic fe);
      wipe_result_t exp_res;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pixel_out %0d frame_end %0b",
                 $time, pix, fe);
        return;
      end
      exp_res = pending_pixels.pop_front();
      if (pix !== exp_res.pixel_out) begin
        errors++;
        $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                 $time, exp_res.pixel_out, pix);
      end
      if (fe !== exp_res.frame_end) begin
        errors++;
        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                 $time, exp_res.frame_end, fe);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CWT_CFG_IDX_W-1:0]  cfg_index;
  logic [CWT_CFG_DATA_W-1:0] cfg_data;

  cwt_in_if  in_ch ();
  cwt_out_if out_ch ();

  wipe_frame_tracker tracker;
  int unsigned       cycle_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       hold_left;
  bit                long_hold_req;

  clock_wipe_transition u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_pixel_pair(in_ch.pixel_prev, in_ch.pixel_cur);
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.compare_output(out_ch.pixel_out, out_ch.frame_end);
      end
    end
  end

  // The receiver stalls at random, or for a long stretch when one is requested.
  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      hold_left     = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 8'd0;
    end else if (r < 20) begin
      return 8'd255;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pixel_pair(input logic [7:0] prev, input logic [7:0] cur);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.pixel_prev <= 8'($urandom);
      in_ch.pixel_cur  <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pixel_prev <= prev;
    in_ch.pixel_cur  <= cur;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CWT_CFG_IDX_W-1:0] idx,
                           input logic [CWT_CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle_outputs();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_directed();
    send_pixel_pair(8'd0, 8'd255);
    send_pixel_pair(8'd255, 8'd0);
    send_pixel_pair(8'hAA, 8'h55);
    settle_outputs();
    write_reg(CFG_FRAME_WIDTH, 16'd0);
    write_reg(CFG_FRAME_HEIGHT, 16'd0);
    write_reg(CFG_FILL_COLOR, 16'hFFFF);
    send_pixel_pair(8'h55, 8'hAA);
    send_pixel_pair(8'd255, 8'd255);
    settle_outputs();
    write_reg(CFG_FRAME_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    write_reg(CFG_SWEEP_SINE, 16'd32768);
    write_reg(CFG_SWEEP_COSINE, 16'd0);
    write_reg(CFG_SECOND_HALF, 16'hFFFF);
    write_reg(CFG_FILL_COLOR, 16'h005A);
    for (int k = 0; k < 6; k++) begin
      send_pixel_pair(8'(k * 40), 8'(255 - k * 40));
    end
    settle_outputs();
    write_reg(CFG_FRAME_WIDTH, 16'h07FF);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    write_reg(CFG_SWEEP_SINE, 16'hFFFF);
    write_reg(CFG_SWEEP_COSINE, 16'hFFFF);
    write_reg(CFG_SECOND_HALF, 16'd0);
    for (int k = 0; k < 4; k++) begin
      send_pixel_pair(8'd255, 8'd0);
    end
    settle_outputs();
    // Writes to unused indexes must leave every setting alone.
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    send_pixel_pair(8'd1, 8'd2);
    send_pixel_pair(8'd128, 8'd127);
    settle_outputs();
    // Shrinking the row mid-frame makes the column counter wrap at once.
    write_reg(CFG_FRAME_WIDTH, 16'd2);
    for (int k = 0; k < 3; k++) begin
      send_pixel_pair(8'd0, 8'd255);
    end
    settle_outputs();
  endtask

  function automatic logic [CWT_CFG_DATA_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return 16'($urandom_range(1, 16));
    end else if (r < 88) begin
      return 16'($urandom_range(17, 64));
    end else if (r < 92) begin
      return 16'd0;
    end else if (r < 96) begin
      return 16'(CWT_MAX_DIM);
    end
    return 16'($urandom_range(CWT_MAX_DIM + 1, 2047)) | 16'($urandom) & 16'hF800;
  endfunction

  function automatic logic [CWT_CFG_DATA_W-1:0] pick_q15();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 16'($urandom_range(0, CWT_Q15_ONE));
    end else if (r < 80) begin
      return 16'd0;
    end else if (r < 90) begin
      return 16'(CWT_Q15_ONE);
    end
    return 16'($urandom_range(CWT_Q15_ONE + 1, 65535));
  endfunction

  task automatic randomize_settings();
    if ($urandom_range(1)) begin
      write_reg(CFG_FRAME_WIDTH, pick_dim());
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_FRAME_HEIGHT, pick_dim());
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_SWEEP_SINE, pick_q15());
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_SWEEP_COSINE, pick_q15());
    end
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_SECOND_HALF, 16'($urandom));
    end
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_FILL_COLOR, 16'($urandom));
    end
    if ($urandom_range(9) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
    end
  endtask

  task automatic run_random();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_count;
    int          hold_at;
    sent        = 0;
    phase_count = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_outputs();
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 51;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      randomize_settings();
      phase_len = $urandom_range(10, 60);
      hold_at   = (phase_count % 6 == 0) ? int'($urandom_range(2, phase_len - 1)) : -1;
      for (int k = 0; k < phase_len; k++) begin
        if (k == hold_at) begin
          long_hold_req = 1'b1;
        end
        send_pixel_pair(pick_pixel(), pick_pixel());
      end
      sent += phase_len;
      phase_count++;
    end
  endtask

  initial begin
    tracker          = new();
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_left        = 0;
    long_hold_req    = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_FRAME_WIDTH;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.pixel_prev = '0;
    in_ch.pixel_cur  = '0;
    out_ch.ready     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    settle_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
